>>> src/hgbs_pkg.sv
`default_nettype none
package hgbs_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int COORD_BITS       = 6;
    localparam int CFG_BITS         = 7;
    localparam int CFG_INDEX_BITS   = 1;
    localparam int DEFAULT_MAX_COLS = 64;
    localparam int GRID_LIMIT       = 64;
    localparam int MIN_DIM          = 3;
    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(50);

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLS = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_ROWS = CFG_INDEX_BITS'(1);

    // Arithmetic widths for the nine-sample sum and the divide by nine.
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int TOTAL_BITS  = SAMPLE_BITS + 4;
    localparam int MAG_BITS    = SAMPLE_BITS + 3;
    localparam int PROD_BITS   = 2 * MAG_BITS;
    localparam int RECIP_SHIFT = 22;
    // ceil(2^22 / 9); exact for every magnitude below 2^21.
    localparam logic [MAG_BITS-1:0] RECIP_NINE = MAG_BITS'(466034);

    localparam int JOB_QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH       = 8;
    localparam int OUT_AW          = 3;
    localparam int OUT_CW          = 4;
    localparam int MAX_PER_ITEM    = 3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] height_in;
        logic                          frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] height_out;
        logic [COORD_BITS-1:0]         out_row;
        logic [COORD_BITS-1:0]         out_col;
        logic                          last_of_run;
    } out_item_t;

    typedef struct packed {
        logic row_one;
        logic mid;
        logic col_is_one;
        logic col_ge_two;
        logic col_last;
        logic last_row;
    } cls_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] height;
        logic [COORD_BITS-1:0]         row;
        logic [COORD_BITS-1:0]         col;
        cls_t                          cls;
    } job_t;

endpackage
`default_nettype wire

>>> src/height_grid_box_smoother_unit.sv
`default_nettype none
// 3x3 box smoother for a height grid streamed in raster order. One sample is
// accepted per cycle while in_stall is low; the front tracks the row and column
// and classifies each sample, a four-entry job queue decouples it from the
// back, and the back reads the two line stores (one read and one write port
// each, MAX_COLS deep but at most 64), forms the nine-sample sum, divides by
// nine with a reciprocal multiply and writes up to three results per sample
// into an eight-beat output buffer. A sample's first result passes the job
// queue, back stages and output buffer; further results of the same sample
// follow one per cycle while out_stall is low. A frame yields as many results
// as samples, but unevenly: row 0 yields none, row 1 one per sample, later
// interior rows none at column 0, one per other sample and a two-beat burst at
// each row end that the output buffer absorbs, and the last row one at column
// 0 and two or three at the others. With the output taking one beat per cycle,
// in_stall therefore rises during the last row of every frame, and whenever
// out_stall holds long enough to fill the output buffer and the job queue.
module height_grid_box_smoother_unit #(
    parameter int MAX_COLS = hgbs_pkg::DEFAULT_MAX_COLS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [hgbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [hgbs_pkg::CFG_BITS-1:0]       cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire hgbs_pkg::in_item_t                  in_item,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output hgbs_pkg::out_item_t                      out_item
);
    import hgbs_pkg::*;

    logic [CFG_BITS-1:0] grid_cols_reg, grid_rows_reg;
    logic                queue_full, job_push, job_pop, job_valid;
    job_t                push_job, head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= CFG_RESET;
            grid_rows_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    hgbs_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .grid_cols  (grid_cols_reg),
        .grid_rows  (grid_rows_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (push_job)
    );

    hgbs_queue #(
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (job_pop),
        .pop_data  (head_job),
        .nonempty  (job_valid)
    );

    hgbs_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (head_job),
        .job_pop   (job_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

>>> src/hgbs_front.sv
`default_nettype none
module hgbs_front #(
    parameter int MAX_COLS = hgbs_pkg::DEFAULT_MAX_COLS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [hgbs_pkg::CFG_BITS-1:0] grid_cols,
    input  wire logic [hgbs_pkg::CFG_BITS-1:0] grid_rows,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire hgbs_pkg::in_item_t            in_item,
    input  wire logic                          queue_full,
    output logic                               job_push,
    output hgbs_pkg::job_t                     job
);
    import hgbs_pkg::*;

    localparam int COL_CAP = (MAX_COLS > GRID_LIMIT) ? GRID_LIMIT : MAX_COLS;

    logic [COORD_BITS-1:0] row_pos_reg, row_pos_next;
    logic [COORD_BITS-1:0] col_pos_reg, col_pos_next;
    logic [CFG_BITS-1:0]   cols_eff, rows_eff;
    logic [COORD_BITS-1:0] r, c;
    logic [CFG_BITS-1:0]   c_inc, r_inc;
    logic                  restart;

    always_comb
    begin
        if (grid_cols > CFG_BITS'(COL_CAP))
            cols_eff = CFG_BITS'(COL_CAP);
        else if (grid_cols < CFG_BITS'(MIN_DIM))
            cols_eff = CFG_BITS'(MIN_DIM);
        else
            cols_eff = grid_cols;
        if (grid_rows > CFG_BITS'(GRID_LIMIT))
            rows_eff = CFG_BITS'(GRID_LIMIT);
        else if (grid_rows < CFG_BITS'(MIN_DIM))
            rows_eff = CFG_BITS'(MIN_DIM);
        else
            rows_eff = grid_rows;
    end

    // A stale position outside the current size also starts a new frame.
    assign restart = in_item.frame_start
                   || (CFG_BITS'(col_pos_reg) >= cols_eff)
                   || (CFG_BITS'(row_pos_reg) >= rows_eff);
    assign r = restart ? '0 : row_pos_reg;
    assign c = restart ? '0 : col_pos_reg;

    assign in_stall = queue_full;
    assign job_push = in_valid && !queue_full;

    always_comb
    begin
        c_inc = CFG_BITS'(c) + CFG_BITS'(1);
        r_inc = CFG_BITS'(r) + CFG_BITS'(1);
        if (c_inc >= cols_eff)
        begin
            col_pos_next = '0;
            row_pos_next = (r_inc >= rows_eff) ? '0 : r_inc[COORD_BITS-1:0];
        end
        else
        begin
            col_pos_next = c_inc[COORD_BITS-1:0];
            row_pos_next = r;
        end
    end

    always_comb
    begin
        job.height         = in_item.height_in;
        job.row            = r;
        job.col            = c;
        job.cls.row_one    = (r == COORD_BITS'(1));
        job.cls.mid        = (r >= COORD_BITS'(2));
        job.cls.col_is_one = (c == COORD_BITS'(1));
        job.cls.col_ge_two = (c >= COORD_BITS'(2));
        job.cls.col_last   = (CFG_BITS'(c) == cols_eff - CFG_BITS'(1));
        job.cls.last_row   = (CFG_BITS'(r) == rows_eff - CFG_BITS'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (job_push)
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

endmodule
`default_nettype wire

>>> src/hgbs_queue.sv
`default_nettype none
module hgbs_queue #(
    parameter int DEPTH = hgbs_pkg::JOB_QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire hgbs_pkg::job_t push_data,
    output logic                full,
    input  wire logic           pop,
    output hgbs_pkg::job_t      pop_data,
    output logic                nonempty
);
    import hgbs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            entries_reg [DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [CW-1:0]   count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = entries_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
            if (pop)
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule
`default_nettype wire

>>> src/hgbs_back.sv
`default_nettype none
module hgbs_back #(
    parameter int MAX_COLS = hgbs_pkg::DEFAULT_MAX_COLS
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    input  wire hgbs_pkg::job_t  job,
    output logic                 job_pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output hgbs_pkg::out_item_t  out_item
);
    import hgbs_pkg::*;

    localparam int LINE_DEPTH = (MAX_COLS > GRID_LIMIT) ? GRID_LIMIT : MAX_COLS;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    // Line stores: rows r-1 and r-2, one read and one write per cycle.
    logic signed [SAMPLE_BITS-1:0] above_mem   [LINE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] two_abv_mem [LINE_DEPTH];

    logic                          adv;

    // Stage 1: job plus registered line store data.
    logic                          s1_valid_reg;
    job_t                          s1_job_reg;
    logic                          fwd_reg;
    logic signed [SAMPLE_BITS-1:0] rd_above_reg, rd_two_reg;
    logic signed [SAMPLE_BITS-1:0] last_x_reg, last_a_reg;
    logic signed [SAMPLE_BITS-1:0] a_cur, b_cur;

    // Window: column sums of columns c-1, c-2 and the row r-1 sample of c-1.
    logic signed [SUM_BITS-1:0]    cs1_reg, cs2_reg;
    logic signed [SAMPLE_BITS-1:0] a1_reg;
    logic signed [SUM_BITS-1:0]    colsum;
    logic signed [TOTAL_BITS-1:0]  total, total_neg;
    logic [MAG_BITS-1:0]           mag;

    // Stage 2: magnitude of the sum.
    logic                          s2_valid_reg;
    job_t                          s2_job_reg;
    logic signed [SAMPLE_BITS-1:0] s2_a_reg, s2_a1_reg;
    logic                          s2_neg_reg;
    logic [MAG_BITS-1:0]           s2_mag_reg;

    // Stage 3: product with the reciprocal of nine.
    logic                          s3_valid_reg;
    job_t                          s3_job_reg;
    logic signed [SAMPLE_BITS-1:0] s3_a_reg, s3_a1_reg;
    logic                          s3_neg_reg;
    logic [PROD_BITS-1:0]          s3_prod_reg;

    logic [SAMPLE_BITS-1:0]        quot;
    logic signed [SAMPLE_BITS-1:0] mean;
    logic [COORD_BITS-1:0]         mid_row;
    logic                          p_on, q_on, l_on;
    out_item_t                     p_res, q_res, l_res;
    out_item_t                     slot [MAX_PER_ITEM];
    logic [1:0]                    n_res;

    out_item_t                     out_mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]             out_wptr_reg, out_rptr_reg;
    logic [OUT_CW-1:0]             out_count_reg;
    logic                          out_pop;

    // The whole pipeline moves only when the output buffer can take a full burst.
    assign adv     = (out_count_reg <= OUT_CW'(OUT_DEPTH - MAX_PER_ITEM));
    assign job_pop = adv && job_valid;

    // A job on the same column as the one just ahead reads stale store data.
    assign a_cur = fwd_reg ? last_x_reg : rd_above_reg;
    assign b_cur = fwd_reg ? last_a_reg : rd_two_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_above_reg <= above_mem[job.col[LINE_AW-1:0]];
            rd_two_reg   <= two_abv_mem[job.col[LINE_AW-1:0]];
            fwd_reg      <= s1_valid_reg && (s1_job_reg.col == job.col);
            s1_job_reg   <= job;
            if (s1_valid_reg)
            begin
                above_mem[s1_job_reg.col[LINE_AW-1:0]]   <= s1_job_reg.height;
                two_abv_mem[s1_job_reg.col[LINE_AW-1:0]] <= a_cur;
                last_x_reg                               <= s1_job_reg.height;
                last_a_reg                               <= a_cur;
            end
        end
    end

    always_comb
    begin
        colsum    = SUM_BITS'(a_cur) + SUM_BITS'(b_cur) + SUM_BITS'(s1_job_reg.height);
        total     = TOTAL_BITS'(colsum) + TOTAL_BITS'(cs1_reg) + TOTAL_BITS'(cs2_reg);
        total_neg = -total;
        mag       = total[TOTAL_BITS-1] ? total_neg[MAG_BITS-1:0] : total[MAG_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_job_reg  <= s1_job_reg;
            s2_a_reg    <= a_cur;
            s2_a1_reg   <= a1_reg;
            s2_neg_reg  <= total[TOTAL_BITS-1];
            s2_mag_reg  <= mag;
            s3_job_reg  <= s2_job_reg;
            s3_a_reg    <= s2_a_reg;
            s3_a1_reg   <= s2_a1_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_prod_reg <= PROD_BITS'(s2_mag_reg) * PROD_BITS'(RECIP_NINE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            cs1_reg      <= '0;
            cs2_reg      <= '0;
            a1_reg       <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= job_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                cs2_reg <= cs1_reg;
                cs1_reg <= colsum;
                a1_reg  <= a_cur;
            end
        end
    end

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign quot    = s3_prod_reg[RECIP_SHIFT +: SAMPLE_BITS];
    assign mean    = s3_neg_reg ? (SAMPLE_BITS'(0) - quot) : quot;
    assign mid_row = s3_job_reg.row - COORD_BITS'(1);

    always_comb
    begin
        p_on = s3_valid_reg && (s3_job_reg.cls.row_one
               || (s3_job_reg.cls.mid
                   && (s3_job_reg.cls.col_is_one || s3_job_reg.cls.col_ge_two)));
        q_on = s3_valid_reg && s3_job_reg.cls.mid && s3_job_reg.cls.col_last;
        l_on = s3_valid_reg && s3_job_reg.cls.last_row;

        p_res.last_of_run = 1'b0;
        if (s3_job_reg.cls.row_one)
        begin
            p_res.height_out = s3_a_reg;
            p_res.out_row    = '0;
            p_res.out_col    = s3_job_reg.col;
        end
        else if (s3_job_reg.cls.col_is_one)
        begin
            p_res.height_out = s3_a1_reg;
            p_res.out_row    = mid_row;
            p_res.out_col    = '0;
        end
        else
        begin
            p_res.height_out = mean;
            p_res.out_row    = mid_row;
            p_res.out_col    = s3_job_reg.col - COORD_BITS'(1);
        end

        q_res.height_out  = s3_a_reg;
        q_res.out_row     = mid_row;
        q_res.out_col     = s3_job_reg.col;
        q_res.last_of_run = 1'b0;

        l_res.height_out  = s3_job_reg.height;
        l_res.out_row     = s3_job_reg.row;
        l_res.out_col     = s3_job_reg.col;
        l_res.last_of_run = 1'b0;

        // The right border result only comes with a first one, so packing is simple.
        slot[0] = p_on ? p_res : l_res;
        slot[1] = q_on ? q_res : l_res;
        slot[2] = l_res;
        n_res   = 2'({1'b0, p_on}) + 2'({1'b0, q_on}) + 2'({1'b0, l_on});
        for (int k = 0; k < MAX_PER_ITEM; k++)
            slot[k].last_of_run = (2'(k) == n_res - 2'd1);
    end

    assign out_valid = (out_count_reg != '0);
    assign out_item  = out_mem_reg[out_rptr_reg];
    assign out_pop   = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < MAX_PER_ITEM; k++)
            begin
                if (2'(k) < n_res)
                    out_mem_reg[out_wptr_reg + OUT_AW'(k)] <= slot[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wptr_reg  <= '0;
            out_rptr_reg  <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (adv)
                out_wptr_reg <= out_wptr_reg + OUT_AW'(n_res);
            if (out_pop)
                out_rptr_reg <= out_rptr_reg + OUT_AW'(1);
            out_count_reg <= out_count_reg + (adv ? OUT_CW'(n_res) : OUT_CW'(0))
                           - OUT_CW'(out_pop);
        end
    end

endmodule
`default_nettype wire
